// File: rtl/fsdl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsdl_pkg
// Shared widths, register indexes, the CORDIC arctangent table and the
// CORDIC stage word for the drag and lift series evaluator.
// ----------------------------------------------------------------------------
package fsdl_pkg;

    localparam int NUM_TERMS_DEF = 4;
    localparam int MAX_TERMS     = 4;

    localparam int ANGLE_W   = 16;
    localparam int COEF_W    = 16;
    localparam int TRIG_W    = 16;
    localparam int CORDIC_W  = 18;
    localparam int PROD_W    = COEF_W + TRIG_W;
    localparam int SUM_W     = PROD_W + 3;
    localparam int OUT_W     = 20;
    localparam int TERMS_W   = 3;
    localparam int CFG_IDX_W = 4;
    localparam int FRAC_DROP = 15;

    localparam int CORDIC_STEPS = 15;
    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 18'sd19898;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TERMS_IN_USE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_COEF_0  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_COEF_1  = 4'd5;

    localparam logic [TERMS_W-1:0] TERMS_RESET = 3'd4;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        logic                       flip;
    } cordic_t;

    // Arctangent of 2^-k in binary-angle units.
    function automatic logic signed [CORDIC_W-1:0] atan_value(input int k);
        logic signed [CORDIC_W-1:0] v;
        case (k)
            0:       v = 18'sd8192;
            1:       v = 18'sd4836;
            2:       v = 18'sd2555;
            3:       v = 18'sd1297;
            4:       v = 18'sd651;
            5:       v = 18'sd326;
            6:       v = 18'sd163;
            7:       v = 18'sd81;
            8:       v = 18'sd41;
            9:       v = 18'sd20;
            10:      v = 18'sd10;
            11:      v = 18'sd5;
            12:      v = 18'sd3;
            13:      v = 18'sd1;
            14:      v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/fsdl_cordic_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsdl_cordic_stage
// One registered rotation-mode CORDIC iteration with a fixed shift.
// ----------------------------------------------------------------------------
module fsdl_cordic_stage #(
    parameter int STEP = 0
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  fsdl_pkg::cordic_t   in_data,
    output logic                out_valid,
    output fsdl_pkg::cordic_t   out_data
);

    logic signed [fsdl_pkg::CORDIC_W-1:0] x_cur;
    logic signed [fsdl_pkg::CORDIC_W-1:0] y_cur;
    logic signed [fsdl_pkg::CORDIC_W-1:0] z_cur;
    logic signed [fsdl_pkg::CORDIC_W-1:0] dx;
    logic signed [fsdl_pkg::CORDIC_W-1:0] dy;
    fsdl_pkg::cordic_t data_next;
    fsdl_pkg::cordic_t data_reg;
    logic              valid_reg;

    always_comb
    begin
        x_cur = in_data.x;
        y_cur = in_data.y;
        z_cur = in_data.z;
        dx    = y_cur >>> STEP;
        dy    = x_cur >>> STEP;
        data_next.flip = in_data.flip;
        if (!z_cur[fsdl_pkg::CORDIC_W-1])
        begin
            data_next.x = x_cur - dx;
            data_next.y = y_cur + dy;
            data_next.z = z_cur - fsdl_pkg::atan_value(STEP);
        end
        else
        begin
            data_next.x = x_cur + dx;
            data_next.y = y_cur - dy;
            data_next.z = z_cur + fsdl_pkg::atan_value(STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef SYNTHESIS
    a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |=> out_valid)
        else $error("CORDIC stage dropped a word");
`endif

endmodule
`default_nettype wire

// File: rtl/fsdl_sincos.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsdl_sincos
// Pipelined sine and cosine of TERM times the input angle: fold, fifteen
// CORDIC stages, then negate folded results and saturate to Q1.15.
// ----------------------------------------------------------------------------
module fsdl_sincos #(
    parameter int TERM = 1
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    input  wire  [fsdl_pkg::ANGLE_W-1:0]       angle,
    output logic                               out_valid,
    output logic signed [fsdl_pkg::TRIG_W-1:0] sin_val,
    output logic signed [fsdl_pkg::TRIG_W-1:0] cos_val
);

    localparam int N = fsdl_pkg::CORDIC_STEPS;
    localparam int CW = fsdl_pkg::CORDIC_W;
    localparam int TW = fsdl_pkg::TRIG_W;

    logic [fsdl_pkg::ANGLE_W-1:0] term_angle;
    logic [fsdl_pkg::ANGLE_W-1:0] folded;
    fsdl_pkg::cordic_t            start_next;
    fsdl_pkg::cordic_t            stage_data [N+1];
    logic [N:0]                   stage_valid;
    logic signed [CW-1:0]         x_fin;
    logic signed [CW-1:0]         y_fin;
    logic signed [TW-1:0]         sin_next;
    logic signed [TW-1:0]         cos_next;
    logic signed [TW-1:0]         sin_reg;
    logic signed [TW-1:0]         cos_reg;
    logic                         post_valid_reg;
    fsdl_pkg::cordic_t            start_reg;
    logic                         start_valid_reg;

    function automatic logic signed [TW-1:0] sat_trig(input logic signed [CW-1:0] v);
        logic signed [TW-1:0] r;
        if (v > CW'(32767))
            r = 16'sh7fff;
        else if (v < -CW'(32768))
            r = -16'sh8000;
        else
            r = v[TW-1:0];
        return r;
    endfunction

    // Angles in the left half plane are rotated by half a turn first.
    always_comb
    begin
        term_angle      = fsdl_pkg::ANGLE_W'(angle * TERM);
        start_next.flip = term_angle[fsdl_pkg::ANGLE_W-1] ^ term_angle[fsdl_pkg::ANGLE_W-2];
        folded          = term_angle;
        if (start_next.flip)
        begin
            folded[fsdl_pkg::ANGLE_W-1] = ~term_angle[fsdl_pkg::ANGLE_W-1];
        end
        start_next.x = fsdl_pkg::CORDIC_START;
        start_next.y = '0;
        start_next.z = CW'($signed(folded));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_valid_reg <= 1'b0;
            post_valid_reg  <= 1'b0;
        end
        else
        begin
            start_valid_reg <= in_valid;
            post_valid_reg  <= stage_valid[N];
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        sin_reg   <= sin_next;
        cos_reg   <= cos_next;
    end

    assign stage_data[0]  = start_reg;
    assign stage_valid[0] = start_valid_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_step
        fsdl_cordic_stage #(
            .STEP(k)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (stage_valid[k]),
            .in_data  (stage_data[k]),
            .out_valid(stage_valid[k+1]),
            .out_data (stage_data[k+1])
        );
    end

    always_comb
    begin
        x_fin = stage_data[N].x;
        y_fin = stage_data[N].y;
        if (stage_data[N].flip)
        begin
            x_fin = -x_fin;
            y_fin = -y_fin;
        end
        cos_next = sat_trig(x_fin);
        sin_next = sat_trig(y_fin);
    end

    assign out_valid = post_valid_reg;
    assign sin_val   = sin_reg;
    assign cos_val   = cos_reg;

`ifndef SYNTHESIS
    a_post_follows: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[N] |=> out_valid)
        else $error("sine/cosine word lost after the last rotation");
`endif

endmodule
`default_nettype wire

// File: rtl/fsdl_series.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsdl_series
// Coefficient products, series sums and round-half-up to Q6.14,
// one register stage each.
// ----------------------------------------------------------------------------
module fsdl_series #(
    parameter int NUM_TERMS = fsdl_pkg::NUM_TERMS_DEF,
    parameter int LANES     = 3
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    input  wire  signed [fsdl_pkg::TRIG_W-1:0] sin_val [LANES],
    input  wire  signed [fsdl_pkg::TRIG_W-1:0] cos_val [LANES],
    input  wire  [fsdl_pkg::TERMS_W-1:0]       terms,
    input  wire  signed [fsdl_pkg::COEF_W-1:0] drag_const,
    input  wire  signed [fsdl_pkg::COEF_W-1:0] drag_coef [LANES],
    input  wire  signed [fsdl_pkg::COEF_W-1:0] lift_coef [LANES],
    output logic                               out_valid,
    output logic signed [fsdl_pkg::OUT_W-1:0]  drag_value,
    output logic signed [fsdl_pkg::OUT_W-1:0]  lift_value
);

    localparam int PW = fsdl_pkg::PROD_W;
    localparam int SW = fsdl_pkg::SUM_W;
    localparam int FD = fsdl_pkg::FRAC_DROP;
    localparam logic [fsdl_pkg::TERMS_W-1:0] TERMS_MAX = fsdl_pkg::TERMS_W'(NUM_TERMS);

    logic [fsdl_pkg::TERMS_W-1:0] n_eff;
    logic [LANES-1:0]             lane_en;
    logic signed [PW-1:0]         drag_prod_next [LANES];
    logic signed [PW-1:0]         lift_prod_next [LANES];
    logic signed [PW-1:0]         drag_prod_reg  [LANES];
    logic signed [PW-1:0]         lift_prod_reg  [LANES];
    logic signed [SW-1:0]         const_next;
    logic signed [SW-1:0]         const_reg;
    logic signed [SW-1:0]         drag_sum_next;
    logic signed [SW-1:0]         lift_sum_next;
    logic signed [SW-1:0]         drag_sum_reg;
    logic signed [SW-1:0]         lift_sum_reg;
    logic signed [SW-1:0]         drag_round;
    logic signed [SW-1:0]         lift_round;
    logic signed [fsdl_pkg::OUT_W-1:0] drag_out_reg;
    logic signed [fsdl_pkg::OUT_W-1:0] lift_out_reg;
    logic                         prod_valid_reg;
    logic                         sum_valid_reg;
    logic                         out_valid_reg;

    // A term count of zero still sums the drag constant; counts above the
    // built term count are capped.
    always_comb
    begin
        n_eff = terms;
        if (terms == '0)
            n_eff = fsdl_pkg::TERMS_W'(1);
        else if (terms > TERMS_MAX)
            n_eff = TERMS_MAX;
        for (int l = 0; l < LANES; l++)
        begin
            lane_en[l] = (fsdl_pkg::TERMS_W'(l + 1) < n_eff);
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (lane_en[l])
            begin
                drag_prod_next[l] = PW'(drag_coef[l]) * PW'(cos_val[l]);
                lift_prod_next[l] = PW'(lift_coef[l]) * PW'(sin_val[l]);
            end
            else
            begin
                drag_prod_next[l] = '0;
                lift_prod_next[l] = '0;
            end
        end
        // cos(0) is exactly one, so the constant is simply shifted up.
        const_next = SW'($signed({drag_const, {FD{1'b0}}}));
    end

    always_comb
    begin
        drag_sum_next = const_reg;
        lift_sum_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            drag_sum_next = drag_sum_next + SW'(drag_prod_reg[l]);
            lift_sum_next = lift_sum_next + SW'(lift_prod_reg[l]);
        end
        drag_round = (drag_sum_reg + SW'(16384)) >>> FD;
        lift_round = (lift_sum_reg + SW'(16384)) >>> FD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            sum_valid_reg  <= prod_valid_reg;
            out_valid_reg  <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            drag_prod_reg[l] <= drag_prod_next[l];
            lift_prod_reg[l] <= lift_prod_next[l];
        end
        const_reg    <= const_next;
        drag_sum_reg <= drag_sum_next;
        lift_sum_reg <= lift_sum_next;
        drag_out_reg <= drag_round[fsdl_pkg::OUT_W-1:0];
        lift_out_reg <= lift_round[fsdl_pkg::OUT_W-1:0];
    end

    assign out_valid  = out_valid_reg;
    assign drag_value = drag_out_reg;
    assign lift_value = lift_out_reg;

`ifndef SYNTHESIS
    a_lane0_off: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !lane_en[0]) |=> (drag_prod_reg[0] == '0 && lift_prod_reg[0] == '0))
        else $error("disabled term leaked into the sums");
    a_first_term_off: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && terms <= fsdl_pkg::TERMS_W'(1)) |-> (lane_en == '0))
        else $error("single-term setting enabled a harmonic");
`endif

endmodule
`default_nettype wire

// File: rtl/fourier_series_drag_lift_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fourier_series_drag_lift_core
// Truncated cosine/sine series of the angle of attack for drag and lift,
// Q2.14 coefficients, CORDIC Q1.15 trigonometry, Q6.14 results.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     start / busy           attack_angle
//  result    done (strobe)          drag_value, lift_value
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One angle is taken every cycle; busy stays low and cfg_ready stays high.
//  Each result passes through one fold stage, fifteen CORDIC stages, one
//  saturate stage, then product, sum and round stages.
//  Results are strobed on done for one cycle and cannot be held off.
//  Reset clears the pipeline valid bits and sets terms_in_use to four and
//  all coefficients to zero.
// ----------------------------------------------------------------------------
module fourier_series_drag_lift_core #(
    parameter int NUM_TERMS = fsdl_pkg::NUM_TERMS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  [fsdl_pkg::ANGLE_W-1:0]        attack_angle,
    output logic                                done,
    output logic signed [fsdl_pkg::OUT_W-1:0]   drag_value,
    output logic signed [fsdl_pkg::OUT_W-1:0]   lift_value,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [fsdl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [fsdl_pkg::COEF_W-1:0]         cfg_data
);

    localparam int LANES   = (NUM_TERMS > 1) ? NUM_TERMS - 1 : 1;
    localparam int LATENCY = fsdl_pkg::CORDIC_STEPS + 5;
    localparam int CIW     = fsdl_pkg::CFG_IDX_W;

    logic [fsdl_pkg::TERMS_W-1:0]        terms_reg;
    logic signed [fsdl_pkg::COEF_W-1:0]  drag_const_reg;
    logic signed [fsdl_pkg::COEF_W-1:0]  drag_coef_reg [LANES];
    logic signed [fsdl_pkg::COEF_W-1:0]  lift_coef_reg [LANES];
    logic                                accept;
    logic                                cfg_write;
    logic [LANES-1:0]                    lane_valid;
    logic signed [fsdl_pkg::TRIG_W-1:0]  sin_val [LANES];
    logic signed [fsdl_pkg::TRIG_W-1:0]  cos_val [LANES];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    // Writes to terms that this build does not evaluate are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terms_reg      <= fsdl_pkg::TERMS_RESET;
            drag_const_reg <= '0;
            for (int l = 0; l < LANES; l++)
            begin
                drag_coef_reg[l] <= '0;
                lift_coef_reg[l] <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == fsdl_pkg::REG_TERMS_IN_USE)
                terms_reg <= cfg_data[fsdl_pkg::TERMS_W-1:0];
            if (cfg_index == fsdl_pkg::REG_DRAG_COEF_0)
                drag_const_reg <= $signed(cfg_data);
            for (int l = 0; l < LANES; l++)
            begin
                if (cfg_index == CIW'(fsdl_pkg::REG_DRAG_COEF_0 + CIW'(l + 1)))
                    drag_coef_reg[l] <= $signed(cfg_data);
                if (cfg_index == CIW'(fsdl_pkg::REG_LIFT_COEF_1 + CIW'(l)))
                    lift_coef_reg[l] <= $signed(cfg_data);
            end
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        fsdl_sincos #(
            .TERM(l + 1)
        ) u_sincos (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (accept),
            .angle    (attack_angle),
            .out_valid(lane_valid[l]),
            .sin_val  (sin_val[l]),
            .cos_val  (cos_val[l])
        );
    end

    fsdl_series #(
        .NUM_TERMS(NUM_TERMS),
        .LANES    (LANES)
    ) u_series (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (&lane_valid),
        .sin_val   (sin_val),
        .cos_val   (cos_val),
        .terms     (terms_reg),
        .drag_const(drag_const_reg),
        .drag_coef (drag_coef_reg),
        .lift_coef (lift_coef_reg),
        .out_valid (done),
        .drag_value(drag_value),
        .lift_value(lift_value)
    );

`ifndef SYNTHESIS
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without a matching input word");
    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_valid == '0) || (lane_valid == '1))
        else $error("trigonometry lanes out of step");
`endif

endmodule
`default_nettype wire

// File: tb/fourier_series_drag_lift_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fourier_series_drag_lift_core_test
// Self-checking bench for the drag and lift series evaluator. A driver sends
// angle words in random bursts and a monitor checks every strobed result
// against a local CORDIC and series predictor. The run moves through several
// register settings, the extremes among them, written only while idle.
// ----------------------------------------------------------------------------
module fourier_series_drag_lift_core_test;

    localparam int ANGLE_W      = fsdl_pkg::ANGLE_W;
    localparam int COEF_W       = fsdl_pkg::COEF_W;
    localparam int OUT_W        = fsdl_pkg::OUT_W;
    localparam int TERMS_W      = fsdl_pkg::TERMS_W;
    localparam int CFG_IDX_W    = fsdl_pkg::CFG_IDX_W;
    localparam int MAX_TERMS    = fsdl_pkg::MAX_TERMS;
    localparam int FRAC_DROP    = fsdl_pkg::FRAC_DROP;
    localparam int CORDIC_STEPS = fsdl_pkg::CORDIC_STEPS;
    localparam logic signed [fsdl_pkg::CORDIC_W-1:0] CORDIC_START = fsdl_pkg::CORDIC_START;
    localparam logic [TERMS_W-1:0]   TERMS_RESET      = fsdl_pkg::TERMS_RESET;
    localparam logic [CFG_IDX_W-1:0] REG_TERMS_IN_USE = fsdl_pkg::REG_TERMS_IN_USE;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_COEF_0  = fsdl_pkg::REG_DRAG_COEF_0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_COEF_1  = fsdl_pkg::REG_LIFT_COEF_1;

    localparam int  CYCLE_LIMIT  = 300000;
    localparam int  DRAIN_CYCLES = 30;
    localparam int  RAND_PHASES  = 10;
    localparam int  RAND_ITEMS   = 90;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_COEF_3 = REG_LIFT_COEF_1 + 4'd2;

    localparam int ATAN_LUT [CORDIC_STEPS] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1
    };

    typedef struct packed {
        logic signed [OUT_W-1:0] drag;
        logic signed [OUT_W-1:0] lift;
    } force_sum_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [ANGLE_W-1:0]         attack_angle = '0;
    logic                       done;
    logic signed [OUT_W-1:0]    drag_value;
    logic signed [OUT_W-1:0]    lift_value;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [COEF_W-1:0]          cfg_data = '0;

    // Local copy of the register file.
    logic [TERMS_W-1:0]         terms_reg = TERMS_RESET;
    logic signed [COEF_W-1:0]   drag_reg [MAX_TERMS] = '{default: '0};
    logic signed [COEF_W-1:0]   lift_reg [MAX_TERMS] = '{default: '0};

    logic [ANGLE_W-1:0]         pending_angles [$];
    force_sum_t                 expected_sums [$];

    int errors         = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    int gap_left       = 0;

    fourier_series_drag_lift_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .attack_angle (attack_angle),
        .done         (done),
        .drag_value   (drag_value),
        .lift_value   (lift_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Rotation-mode CORDIC with the half-turn fold, Q1.15 results.
    function automatic void cordic_sincos(input logic [ANGLE_W-1:0] ang,
                                          output int sin_q15, output int cos_q15);
        logic [ANGLE_W-1:0] a;
        bit flip;
        int x, y, z, dx, dy;
        a = ang;
        flip = 1'b0;
        if (a >= 16'd16384 && a < 16'd49152)
        begin
            a = a - 16'd32768;
            flip = 1'b1;
        end
        x = int'(CORDIC_START);
        y = 0;
        z = int'($signed(a));
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_LUT[k];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_LUT[k];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cos_q15 = (x > 32767) ? 32767 : ((x < -32768) ? -32768 : x);
        sin_q15 = (y > 32767) ? 32767 : ((y < -32768) ? -32768 : y);
    endfunction

    function automatic force_sum_t predict_series(input logic [ANGLE_W-1:0] angle);
        int n, s, c;
        longint drag_acc, lift_acc, rounded;
        logic [ANGLE_W-1:0] harmonic;
        force_sum_t res;
        n = int'(terms_reg);
        if (n < 1)
            n = 1;
        if (n > MAX_TERMS)
            n = MAX_TERMS;
        drag_acc = longint'(drag_reg[0]) * 32768;
        lift_acc = 0;
        for (int i = 1; i < n; i++)
        begin
            harmonic = angle * 16'(i);
            cordic_sincos(harmonic, s, c);
            drag_acc += longint'(drag_reg[i]) * longint'(c);
            lift_acc += longint'(lift_reg[i]) * longint'(s);
        end
        rounded = (drag_acc + 16384) >>> FRAC_DROP;
        res.drag = OUT_W'(rounded);
        rounded = (lift_acc + 16384) >>> FRAC_DROP;
        res.lift = OUT_W'(rounded);
        return res;
    endfunction

    // Call at a rising edge; returns at a rising edge with valid low.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_TERMS_IN_USE)
            terms_reg = val[TERMS_W-1:0];
        else if (idx >= REG_DRAG_COEF_0 && idx < REG_LIFT_COEF_1)
            drag_reg[idx - REG_DRAG_COEF_0] = val;
        else if (idx >= REG_LIFT_COEF_1 && idx <= REG_LIFT_COEF_3)
            lift_reg[idx - REG_LIFT_COEF_1 + 1] = val;
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [TERMS_W-1:0] terms,
                             input logic [COEF_W-1:0] d0, input logic [COEF_W-1:0] d1,
                             input logic [COEF_W-1:0] d2, input logic [COEF_W-1:0] d3,
                             input logic [COEF_W-1:0] l1, input logic [COEF_W-1:0] l2,
                             input logic [COEF_W-1:0] l3);
        write_reg(REG_TERMS_IN_USE, COEF_W'(terms));
        write_reg(REG_DRAG_COEF_0, d0);
        write_reg(REG_DRAG_COEF_0 + 4'd1, d1);
        write_reg(REG_DRAG_COEF_0 + 4'd2, d2);
        write_reg(REG_DRAG_COEF_0 + 4'd3, d3);
        write_reg(REG_LIFT_COEF_1, l1);
        write_reg(REG_LIFT_COEF_1 + 4'd1, l2);
        write_reg(REG_LIFT_COEF_3, l3);
    endtask

    // Everything sent has come back; then let the pipeline settle.
    task automatic wait_idle();
        while (pending_angles.size() > 0 || start || expected_sums.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 11))
            0, 1:    return 16'h8000;
            2, 3:    return 16'h7FFF;
            4:       return 16'h0000;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] rand_angle();
        case ($urandom_range(0, 3))
            0, 1:    return ANGLE_W'($urandom);
            // Close to a quadrant boundary, where the fold switches.
            2:       return ANGLE_W'($urandom_range(0, 3) * 16384 + $urandom_range(0, 8) - 4);
            default: return ANGLE_W'($urandom_range(0, 31) * 2048);
        endcase
    endfunction

    // Driver: one angle word per free slot, in bursts with gaps between them.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_sums.push_back(predict_series(attack_angle));
                items_accepted++;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_angles.size() > 0)
                begin
                    start        <= 1'b1;
                    attack_angle <= pending_angles.pop_front();
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1, 2:    gap_left = $urandom_range(1, 6);
                            default: gap_left = $urandom_range(7, 30);
                        endcase
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: results cannot be held off, so every strobe is checked.
    always @(posedge clk)
    begin
        force_sum_t exp_sum;
        if (rst_n && done)
        begin
            if (expected_sums.size() == 0)
            begin
                $display("%0t: result with nothing expected: drag %0d lift %0d",
                         $time, drag_value, lift_value);
                errors++;
            end
            else
            begin
                exp_sum = expected_sums.pop_front();
                results_seen++;
                if (drag_value !== exp_sum.drag)
                begin
                    $display("%0t: drag_value expected %0d actual %0d",
                             $time, exp_sum.drag, drag_value);
                    errors++;
                end
                if (lift_value !== exp_sum.lift)
                begin
                    $display("%0t: lift_value expected %0d actual %0d",
                             $time, exp_sum.lift, lift_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_sums.size());
            $display("fourier_series_drag_lift_core_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [ANGLE_W-1:0] corner_angles [8];
        logic [TERMS_W-1:0] terms;
        corner_angles = '{16'd0, 16'd1, 16'd8192, 16'd16383,
                          16'd16384, 16'd32768, 16'd49151, 16'd65535};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: four terms, all coefficients zero.
        pending_angles.push_back(16'd12345);
        pending_angles.push_back(16'd49152);
        wait_idle();

        write_all(3'd4, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        foreach (corner_angles[i])
            pending_angles.push_back(corner_angles[i]);
        wait_idle();

        write_all(3'd4, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        foreach (corner_angles[i])
            pending_angles.push_back(corner_angles[i]);
        wait_idle();

        // A term count of zero acts as one, and seven, above the maximum, as four.
        write_all(3'd0, 16'h4000, 16'h8000, 16'h7FFF, 16'h1234, 16'h7FFF, 16'h8000, 16'hC000);
        pending_angles.push_back(16'd21845);
        pending_angles.push_back(16'd43690);
        wait_idle();
        write_reg(REG_TERMS_IN_USE, 16'hFFFF);
        pending_angles.push_back(16'd21845);
        pending_angles.push_back(16'd5461);
        wait_idle();
        // Indexes past the last register are ignored.
        write_reg(4'd15, 16'h5555);
        write_reg(REG_TERMS_IN_USE, 16'd1);
        pending_angles.push_back(16'd32767);
        pending_angles.push_back(16'd40000);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p % 3 == 0)
            begin
                terms = ($urandom_range(0, 4) == 0) ? TERMS_W'($urandom_range(0, 7))
                                                    : TERMS_W'($urandom_range(1, 4));
                write_all(terms, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                          rand_coef(), rand_coef(), rand_coef());
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    case ($urandom_range(0, 5))
                        0:       write_reg(REG_TERMS_IN_USE, COEF_W'($urandom));
                        1:       write_reg(CFG_IDX_W'($urandom_range(8, 15)), COEF_W'($urandom));
                        default: write_reg(CFG_IDX_W'($urandom_range(1, 7)), rand_coef());
                    endcase
                end
                if (terms_reg < 3'd1 || terms_reg > 3'd4)
                    if ($urandom_range(0, 1) == 0)
                        write_reg(REG_TERMS_IN_USE, COEF_W'($urandom_range(1, 4)));
            end
            repeat (RAND_ITEMS)
                pending_angles.push_back(rand_angle());
            wait_idle();
        end

        $display("Covered %0d angle words and %0d results over %0d register writes,",
                 items_accepted, results_seen, reg_writes);
        $display("including coefficient extremes and term counts from zero to seven.");
        if (errors == 0 && expected_sums.size() == 0)
        begin
            $display("fourier_series_drag_lift_core_test: PASS");
        end
        else
        begin
            $display("fourier_series_drag_lift_core_test: FAIL");
        end
        $finish;
    end

endmodule
